@@ rtl/core/spd_pwm_pkg.sv @@
// ---------------------------------------------------------------------------
// Spindle PWM drive package
// Widths, register indexes, reset values, run-state and command-mode codes and channel payload types.
// ---------------------------------------------------------------------------
`default_nettype none

package spd_pwm_pkg;

    // Field widths
    localparam int SPEED_BITS = 20;
    localparam int DUTY_BITS  = 16;
    localparam int CFG_DATA_W = (SPEED_BITS > DUTY_BITS) ? SPEED_BITS : DUTY_BITS;
    localparam int CFG_IDX_W  = 3;

    // Divider sizing: product of speed offset and duty span
    localparam int PROD_W = SPEED_BITS + DUTY_BITS;
    localparam int CNT_W  = $clog2(PROD_W);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_DUTY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FWD_REV_PINS = 3'd5;

    // Reset values
    localparam logic [SPEED_BITS-1:0] MAX_SPEED_RST = SPEED_BITS'(10000);

    // Run states
    localparam logic [1:0] RUN_UNCONF  = 2'd0;
    localparam logic [1:0] RUN_STOPPED = 2'd1;
    localparam logic [1:0] RUN_FWD     = 2'd2;
    localparam logic [1:0] RUN_REV     = 2'd3;

    // Command modes
    localparam logic MODE_SET_SPEED = 1'b0;
    localparam logic MODE_SET_STATE = 1'b1;

    typedef struct packed {
        logic                  mode;
        logic [SPEED_BITS-1:0] speed_req;
        logic                  apply_now;
        logic [1:0]            new_run_state;
    } spd_in_t;

    typedef struct packed {
        logic                  enable_pin;
        logic                  reverse_pin;
        logic [DUTY_BITS-1:0]  duty;
        logic [SPEED_BITS-1:0] applied_speed;
        logic [1:0]            run_state_now;
    } spd_out_t;

endpackage

`default_nettype wire

@@ rtl/core/spindle_speed_to_pwm_drive_core.sv @@
// ---------------------------------------------------------------------------
// Spindle speed to PWM drive core
// Run-state control and linear speed-to-duty mapping with a single
// multiply step and a bit-serial restoring divider.
// ---------------------------------------------------------------------------
//  channel | ports                          | direction | payload
//  --------+--------------------------------+-----------+-------------------
//  request | s_valid s_ready s_data         | in        | spd_in_t
//  result  | m_valid m_ready m_data         | out       | spd_out_t
//  config  | cfg_wr_en cfg_index cfg_wdata  | in        | register write
//
//  A running request that applies a nonzero speed with a valid speed range
//  passes through accept, one multiply, PROD_W divider steps and a result
//  load; any other request goes from accept straight to the result load.
//  Reset is synchronous, active low, on aresetn. A new request is taken
//  while a finished result waits in the output register; the next result
//  is held internally until that register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module spindle_speed_to_pwm_drive_core (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire  spd_pwm_pkg::spd_in_t          s_data,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output spd_pwm_pkg::spd_out_t               m_data,
    input  wire                                 cfg_wr_en,
    input  wire  [spd_pwm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [spd_pwm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int SB = spd_pwm_pkg::SPEED_BITS;
    localparam int DB = spd_pwm_pkg::DUTY_BITS;
    localparam int PW = spd_pwm_pkg::PROD_W;
    localparam int CW = spd_pwm_pkg::CNT_W;

    // Sequencer codes
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // Configuration registers
    logic [DB-1:0] min_duty_reg, min_duty_next;
    logic [DB-1:0] max_duty_reg, max_duty_next;
    logic [DB-1:0] idle_duty_reg, idle_duty_next;
    logic [SB-1:0] min_speed_reg, min_speed_next;
    logic [SB-1:0] max_speed_reg, max_speed_next;
    logic          fwd_rev_reg, fwd_rev_next;

    // Drive state
    logic [1:0]    run_state_reg, run_state_next;
    logic [SB-1:0] target_reg, target_next;
    logic [SB-1:0] applied_reg, applied_next;
    logic          enable_reg, enable_next;
    logic          reverse_reg, reverse_next;
    logic [DB-1:0] duty_reg, duty_next;

    // Sequencer and arithmetic unit
    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [SB-1:0] mula_reg, mula_next;
    logic [DB-1:0] mulb_reg, mulb_next;
    logic          neg_reg, neg_next;
    logic [SB-1:0] span_reg, span_next;
    logic [SB-1:0] rem_reg, rem_next;
    logic [PW-1:0] num_reg, num_next;

    // Output register
    logic                  m_valid_reg, m_valid_next;
    spd_pwm_pkg::spd_out_t m_data_reg, m_data_next;

    // Request decode
    logic          accept;
    logic [1:0]    rs_sel;
    logic [SB-1:0] s_sel;
    logic          do_apply;
    logic [SB-1:0] clamped;
    logic          range_ok;
    logic          duty_neg;
    logic [DB-1:0] duty_span;

    // Divider step
    logic [SB:0]   trial;
    logic          trial_ge;
    logic [SB:0]   trial_sub;
    logic [DB-1:0] quot;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Pick the run state and speed that this request applies
    assign rs_sel   = (s_data.mode == spd_pwm_pkg::MODE_SET_STATE) ?
                      s_data.new_run_state : run_state_reg;
    assign s_sel    = (s_data.mode == spd_pwm_pkg::MODE_SET_STATE) ?
                      target_reg : s_data.speed_req;
    assign do_apply = (s_data.mode == spd_pwm_pkg::MODE_SET_STATE) || s_data.apply_now;

    // Clamp to the speed range, low bound checked first
    assign clamped   = (s_sel < min_speed_reg) ? min_speed_reg :
                       (s_sel > max_speed_reg) ? max_speed_reg : s_sel;
    assign range_ok  = (max_speed_reg > min_speed_reg);
    assign duty_neg  = (max_duty_reg < min_duty_reg);
    assign duty_span = duty_neg ? (min_duty_reg - max_duty_reg)
                                : (max_duty_reg - min_duty_reg);

    // Restoring divider step: shift in one product bit, subtract if it fits
    assign trial     = {rem_reg, num_reg[PW-1]};
    assign trial_ge  = (trial >= {1'b0, span_reg});
    assign trial_sub = trial - {1'b0, span_reg};
    assign quot      = {num_reg[DB-2:0], trial_ge};

    always_comb begin
        min_duty_next  = min_duty_reg;
        max_duty_next  = max_duty_reg;
        idle_duty_next = idle_duty_reg;
        min_speed_next = min_speed_reg;
        max_speed_next = max_speed_reg;
        fwd_rev_next   = fwd_rev_reg;
        run_state_next = run_state_reg;
        target_next    = target_reg;
        applied_next   = applied_reg;
        enable_next    = enable_reg;
        reverse_next   = reverse_reg;
        duty_next      = duty_reg;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mula_next      = mula_reg;
        mulb_next      = mulb_reg;
        neg_next       = neg_reg;
        span_next      = span_reg;
        rem_next       = rem_reg;
        num_next       = num_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        // Register writes; any known register sets the run state to stopped unless a request is accepted too
        if (cfg_wr_en) begin
            case (cfg_index)
                spd_pwm_pkg::REG_MIN_DUTY: begin
                    min_duty_next  = cfg_wdata[DB-1:0];
                    run_state_next = spd_pwm_pkg::RUN_STOPPED;
                end
                spd_pwm_pkg::REG_MAX_DUTY: begin
                    max_duty_next  = cfg_wdata[DB-1:0];
                    run_state_next = spd_pwm_pkg::RUN_STOPPED;
                end
                spd_pwm_pkg::REG_IDLE_DUTY: begin
                    idle_duty_next = cfg_wdata[DB-1:0];
                    run_state_next = spd_pwm_pkg::RUN_STOPPED;
                end
                spd_pwm_pkg::REG_MIN_SPEED: begin
                    min_speed_next = cfg_wdata[SB-1:0];
                    run_state_next = spd_pwm_pkg::RUN_STOPPED;
                end
                spd_pwm_pkg::REG_MAX_SPEED: begin
                    max_speed_next = cfg_wdata[SB-1:0];
                    run_state_next = spd_pwm_pkg::RUN_STOPPED;
                end
                spd_pwm_pkg::REG_FWD_REV_PINS: begin
                    fwd_rev_next   = cfg_wdata[0];
                    run_state_next = spd_pwm_pkg::RUN_STOPPED;
                end
                default: begin
                end
            endcase
        end

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    run_state_next = rs_sel;
                    if (s_data.mode == spd_pwm_pkg::MODE_SET_SPEED) begin
                        target_next = s_data.speed_req;
                    end
                    state_next = S_DONE;
                    if (do_apply) begin
                        if ((rs_sel == spd_pwm_pkg::RUN_STOPPED) || (s_sel == '0)) begin
                            enable_next  = 1'b0;
                            reverse_next = 1'b0;
                            duty_next    = idle_duty_reg;
                            applied_next = '0;
                        end else if (rs_sel != spd_pwm_pkg::RUN_UNCONF) begin
                            applied_next = clamped;
                            if (rs_sel == spd_pwm_pkg::RUN_FWD) begin
                                enable_next  = 1'b1;
                                reverse_next = 1'b0;
                            end else begin
                                enable_next  = !fwd_rev_reg;
                                reverse_next = 1'b1;
                            end
                            if (range_ok) begin
                                mula_next  = clamped - min_speed_reg;
                                mulb_next  = duty_span;
                                neg_next   = duty_neg;
                                span_next  = max_speed_reg - min_speed_reg;
                                state_next = S_MUL;
                            end else begin
                                duty_next = min_duty_reg;
                            end
                        end
                    end
                end
            end
            S_MUL: begin
                num_next   = PW'(mula_reg) * PW'(mulb_reg);
                rem_next   = '0;
                cnt_next   = CW'(PW - 1);
                state_next = S_DIV;
            end
            S_DIV: begin
                rem_next = trial_ge ? trial_sub[SB-1:0] : trial[SB-1:0];
                num_next = {num_reg[PW-2:0], trial_ge};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0) begin
                    // Quotient never exceeds the duty span, so no saturation
                    duty_next  = neg_reg ? (min_duty_reg - quot) : (min_duty_reg + quot);
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.enable_pin    = enable_reg;
                    m_data_next.reverse_pin   = reverse_reg;
                    m_data_next.duty          = duty_reg;
                    m_data_next.applied_speed = applied_reg;
                    m_data_next.run_state_now = run_state_reg;
                    m_valid_next              = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_duty_reg  <= '0;
            max_duty_reg  <= '1;
            idle_duty_reg <= '0;
            min_speed_reg <= '0;
            max_speed_reg <= spd_pwm_pkg::MAX_SPEED_RST;
            fwd_rev_reg   <= 1'b0;
            run_state_reg <= spd_pwm_pkg::RUN_UNCONF;
            target_reg    <= '0;
            applied_reg   <= '0;
            enable_reg    <= 1'b0;
            reverse_reg   <= 1'b0;
            duty_reg      <= '0;
            state_reg     <= S_IDLE;
            m_valid_reg   <= 1'b0;
        end else begin
            min_duty_reg  <= min_duty_next;
            max_duty_reg  <= max_duty_next;
            idle_duty_reg <= idle_duty_next;
            min_speed_reg <= min_speed_next;
            max_speed_reg <= max_speed_next;
            fwd_rev_reg   <= fwd_rev_next;
            run_state_reg <= run_state_next;
            target_reg    <= target_next;
            applied_reg   <= applied_next;
            enable_reg    <= enable_next;
            reverse_reg   <= reverse_next;
            duty_reg      <= duty_next;
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        mula_reg   <= mula_next;
        mulb_reg   <= mulb_next;
        neg_reg    <= neg_next;
        span_reg   <= span_next;
        rem_reg    <= rem_next;
        num_reg    <= num_next;
        m_data_reg <= m_data_next;
    end

`ifndef SYNTHESIS
    // Leave idle after every accepted request
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != S_IDLE))
        else $error("sequencer stayed idle after accept");

    // Partial remainder stays below the divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (rem_reg < span_reg))
        else $error("divider remainder out of range");

    // Final quotient fits the duty width
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_DIV) && (cnt_reg == '0)) |-> (num_next[PW-1:DB] == '0))
        else $error("quotient exceeds duty width");

    // Loaded result carries the current run state
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_DONE) && (!m_valid_reg || m_ready)) |=>
        (m_valid_reg && (m_data_reg.run_state_now == run_state_reg)))
        else $error("result not loaded from drive state");
`endif

endmodule

`default_nettype wire
